>>> design/assert_macros.svh
// Assertion macros shared by the chunked body decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on rising clk_i, suspended while rst_ni is low.
`define HCD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked on every rising clk_i, reset included.
`define HCD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

>>> design/hcd_pkg.sv
// Types and constants for the chunked body decoder.
package hcd_pkg;

  localparam int unsigned LineLimitDef = 32;
  localparam int unsigned FifoDepthDef = 2;

  localparam int unsigned LenW = 25;
  localparam logic [LenW-1:0] LenCap = 25'h100_0000;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [3:0] HexAlphaBase = 4'd10;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindChunk = 2'd1,
    KindMsg   = 2'd2,
    KindErr   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone = 3'd0,
    ErrLong = 3'd1,
    ErrHex  = 3'd2,
    ErrBig  = 3'd3,
    ErrTerm = 3'd4
  } err_e;

  // Classified input byte, front to back.
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       payload;
    logic [LenW-1:0]  length;
    err_e             code;
  } result_t;

endpackage

>>> design/hcd_front.sv
// Input side: takes bytes and classifies them for the parser.
module hcd_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tuser,   // restart
  output logic              push_valid_o,
  output hcd_pkg::item_t    push_item_o,
  input  logic              push_ready_i
);

  hcd_pkg::item_t item;

  always_comb begin
    item         = '0;
    item.restart = s_axis_tuser;
    item.data    = s_axis_tdata;
    item.is_cr   = (s_axis_tdata == hcd_pkg::ChCr);
    item.is_lf   = (s_axis_tdata == hcd_pkg::ChLf);
    if (s_axis_tdata >= 8'h30 && s_axis_tdata <= 8'h39) begin
      item.is_hex  = 1'b1;
      item.hex_val = s_axis_tdata[3:0];
    end else if ((s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h66) ||
                 (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h46)) begin
      item.is_hex  = 1'b1;
      item.hex_val = (s_axis_tdata[3:0] - 4'd1) + hcd_pkg::HexAlphaBase;
    end
  end

  assign push_valid_o  = s_axis_tvalid;
  assign push_item_o   = item;
  assign s_axis_tready = push_ready_i;

endmodule

>>> design/hcd_fifo.sv
// Short queue of classified bytes between front and parser.
`include "assert_macros.svh"

module hcd_fifo #(
  parameter int unsigned DEPTH = hcd_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hcd_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output hcd_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  hcd_pkg::item_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `HCD_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CntW'(DEPTH)))
  `HCD_ASSERT(a_count_grow, (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))

endmodule

>>> design/hcd_back.sv
// Parser: length lines, payload, terminators and trailer, with result register.
`include "assert_macros.svh"

module hcd_back #(
  parameter int unsigned LINE_LIMIT = hcd_pkg::LineLimitDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hcd_pkg::LenW-1:0]   cfg_wdata_i,
  input  logic                       item_valid_i,
  input  hcd_pkg::item_t             item_i,
  output logic                       item_ready_o,
  output logic                       res_valid_o,
  output hcd_pkg::result_t           res_o,
  input  logic                       res_ready_i
);

  localparam int unsigned LenW = hcd_pkg::LenW;
  localparam int unsigned LbW  = $clog2(LINE_LIMIT + 1);
  localparam int unsigned LbNW = LbW + 1;

  localparam logic [1:0] PhLine  = 2'd0;
  localparam logic [1:0] PhData  = 2'd1;
  localparam logic [1:0] PhTrail = 2'd2;
  localparam logic [1:0] PhHalt  = 2'd3;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultHex  = 2'd1;
  localparam logic [1:0] FaultBig  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [LbW-1:0]  line_bytes_q, line_bytes_d;
  logic [LenW-1:0] hex_value_q, hex_value_d;
  logic [1:0]      fault_q, fault_d;
  logic            cr_q, cr_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic [LenW-1:0] saved_len_q, saved_len_d;
  logic            held_cr_q, held_cr_d;
  logic [1:0]      tlb_q, tlb_d;
  logic [LenW-1:0] max_len_q;

  logic             res_valid_q, res_valid_d;
  hcd_pkg::result_t res_q, res_d;

  logic             fire, emit;
  hcd_pkg::result_t res_new;
  logic [LbNW-1:0]  line_n;
  logic [LenW+3:0]  hv_shift;
  logic             hv_big;
  logic [1:0]       tlb_n;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign line_n       = {1'b0, line_bytes_q} + LbNW'(1);
  assign hv_shift     = {hex_value_q, item_i.hex_val};
  assign hv_big       = hv_shift > {4'b0000, max_len_q};
  assign tlb_n        = (tlb_q == 2'd3) ? 2'd3 : tlb_q + 2'd1;

  always_comb begin
    phase_d      = phase_q;
    line_bytes_d = line_bytes_q;
    hex_value_d  = hex_value_q;
    fault_d      = fault_q;
    cr_d         = cr_q;
    bytes_left_d = bytes_left_q;
    saved_len_d  = saved_len_q;
    held_cr_d    = held_cr_q;
    tlb_d        = tlb_q;
    emit         = 1'b0;
    res_new      = '0;

    if (fire) begin
      if (item_i.restart) begin
        phase_d      = PhLine;
        line_bytes_d = '0;
        hex_value_d  = '0;
        fault_d      = FaultNone;
        cr_d         = 1'b0;
        bytes_left_d = '0;
        saved_len_d  = '0;
        held_cr_d    = 1'b0;
        tlb_d        = '0;
      end else begin
        unique case (phase_q)
          PhLine: begin
            if (line_n > LbNW'(LINE_LIMIT)) begin
              phase_d      = PhHalt;
              emit         = 1'b1;
              res_new.kind = hcd_pkg::KindErr;
              res_new.code = hcd_pkg::ErrLong;
            end else begin
              line_bytes_d = line_n[LbW-1:0];
              if (item_i.is_lf && cr_q && line_n > LbNW'(2)) begin
                cr_d = 1'b0;
                priority if (fault_q == FaultHex) begin
                  phase_d      = PhHalt;
                  emit         = 1'b1;
                  res_new.kind = hcd_pkg::KindErr;
                  res_new.code = hcd_pkg::ErrHex;
                end else if (fault_q == FaultBig) begin
                  phase_d      = PhHalt;
                  emit         = 1'b1;
                  res_new.kind = hcd_pkg::KindErr;
                  res_new.code = hcd_pkg::ErrBig;
                end else if (hex_value_q == '0) begin
                  phase_d = PhTrail;
                  tlb_d   = '0;
                end else begin
                  bytes_left_d = hex_value_q;
                  saved_len_d  = hex_value_q;
                  phase_d      = PhData;
                end
              end else begin
                cr_d = item_i.is_cr;
                // a pending CR that is not part of CR LF is a non-hex byte
                if (fault_q == FaultNone) begin
                  if (cr_q) begin
                    fault_d = FaultHex;
                  end else if (!item_i.is_cr) begin
                    if (item_i.is_hex) begin
                      hex_value_d = hv_shift[LenW-1:0];
                      if (hv_big) begin
                        fault_d = FaultBig;
                      end
                    end else begin
                      fault_d = FaultHex;
                    end
                  end
                end
              end
            end
          end
          PhData: begin
            if (bytes_left_q != '0) begin
              bytes_left_d    = bytes_left_q - LenW'(1);
              emit            = 1'b1;
              res_new.kind    = hcd_pkg::KindByte;
              res_new.payload = item_i.data;
            end else if (!cr_q) begin
              held_cr_d = item_i.is_cr;
              cr_d      = 1'b1;
            end else if (!held_cr_q || !item_i.is_lf) begin
              phase_d      = PhHalt;
              emit         = 1'b1;
              res_new.kind = hcd_pkg::KindErr;
              res_new.code = hcd_pkg::ErrTerm;
            end else begin
              phase_d        = PhLine;
              line_bytes_d   = '0;
              hex_value_d    = '0;
              fault_d        = FaultNone;
              cr_d           = 1'b0;
              emit           = 1'b1;
              res_new.kind   = hcd_pkg::KindChunk;
              res_new.length = saved_len_q;
            end
          end
          PhTrail: begin
            if (item_i.is_lf && cr_q) begin
              cr_d  = 1'b0;
              tlb_d = '0;
              if (tlb_n == 2'd2) begin
                phase_d      = PhLine;
                line_bytes_d = '0;
                hex_value_d  = '0;
                fault_d      = FaultNone;
                emit         = 1'b1;
                res_new.kind = hcd_pkg::KindMsg;
              end
            end else begin
              tlb_d = tlb_n;
              cr_d  = item_i.is_cr;
            end
          end
          PhHalt: begin
          end
          default: begin
          end
        endcase
      end
    end

    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    if (emit) begin
      res_valid_d = 1'b1;
      res_d       = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLine;
      line_bytes_q <= '0;
      hex_value_q  <= '0;
      fault_q      <= FaultNone;
      cr_q         <= 1'b0;
      bytes_left_q <= '0;
      saved_len_q  <= '0;
      held_cr_q    <= 1'b0;
      tlb_q        <= '0;
      max_len_q    <= hcd_pkg::LenCap;
      res_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      line_bytes_q <= line_bytes_d;
      hex_value_q  <= hex_value_d;
      fault_q      <= fault_d;
      cr_q         <= cr_d;
      bytes_left_q <= bytes_left_d;
      saved_len_q  <= saved_len_d;
      held_cr_q    <= held_cr_d;
      tlb_q        <= tlb_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i[LenW-1] ? hcd_pkg::LenCap : cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `HCD_ASSERT(a_left_in_data, (bytes_left_q != '0) |-> (phase_q == PhData))
  `HCD_ASSERT(a_err_has_code,
              (res_valid_q && res_q.kind == hcd_pkg::KindErr) |-> (res_q.code != hcd_pkg::ErrNone))
  `HCD_ASSERT(a_halt_silent,
              (fire && phase_q == PhHalt && !item_i.restart) |=> (phase_q == PhHalt))

endmodule

>>> design/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
//
//  channel  | direction | handshake                    | content
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata data_byte, tuser restart
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata payload/length/code, tuser kind
//  cfg      | in        | cfg_we_i                     | cfg_wdata_i max_chunk_len
//
// One byte per cycle sustained while m_axis_tready is high; the parser then handles one
// queued byte per cycle. Bytes are registered in the queue, results in the parser.
// Reset is asynchronous; max_chunk_len comes up as 16777216, no clearing pass.
// An output stall fills the queue, after which s_axis_tready drops.
module http_chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT = hcd_pkg::LineLimitDef,
  parameter int unsigned FIFO_DEPTH = hcd_pkg::FifoDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [hcd_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] data_byte
  input  logic                     s_axis_tuser,   // [0] restart
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [39:0]              m_axis_tdata,   // [7:0] payload_byte, [32:8] chunk_length,
                                                   // [35:33] error_code, [39:36] zero
  output logic [1:0]               m_axis_tuser    // [1:0] kind
);

  logic             push_valid, push_ready;
  hcd_pkg::item_t   push_item;
  logic             pop_valid, pop_ready;
  hcd_pkg::item_t   pop_item;
  hcd_pkg::result_t res;

  hcd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  hcd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  hcd_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, res.code, res.length, res.payload};
  assign m_axis_tuser = res.kind;

endmodule

>>> tb/http_chunked_body_decoder_test.sv
// Self-checking testbench for the chunked body decoder: random chunked streams against a predictor.
`timescale 1ns / 100ps

module http_chunked_body_decoder_test;

  localparam int unsigned LineLimit = hcd_pkg::LineLimitDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems = 250;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } body_item_t;

  typedef enum logic [1:0] {RxOpen, RxLight, RxHeavy, RxPattern} rx_mode_e;

  class chunked_decode_sb;
    typedef enum logic [1:0] {PhLine, PhData, PhTrail, PhHalt} parse_phase_e;
    typedef enum logic [1:0] {FaultNone, FaultHex, FaultBig} line_fault_e;

    logic [hcd_pkg::LenW-1:0] max_len;
    parse_phase_e             phase;
    int unsigned              line_bytes;
    logic [31:0]              hex_acc;
    line_fault_e              fault;
    bit                       cr_seen;
    logic [hcd_pkg::LenW-1:0] bytes_left;
    logic [hcd_pkg::LenW-1:0] chunk_len;
    logic [7:0]               first_term;
    int unsigned              trail_bytes;
    hcd_pkg::result_t         awaited_results[$];
    int unsigned              failures, payloads, chunk_ends, msg_ends, errors;

    function new();
      max_len = hcd_pkg::LenCap;
      failures = 0;
      payloads = 0;
      chunk_ends = 0;
      msg_ends = 0;
      errors = 0;
      clear_parser();
    endfunction

    function void clear_line();
      line_bytes = 0;
      hex_acc = '0;
      fault = FaultNone;
      cr_seen = 1'b0;
    endfunction

    function void clear_parser();
      phase = PhLine;
      clear_line();
      bytes_left = '0;
      chunk_len = '0;
      first_term = '0;
      trail_bytes = 0;
    endfunction

    function void set_limit(logic [hcd_pkg::LenW-1:0] value);
      max_len = (value > hcd_pkg::LenCap) ? hcd_pkg::LenCap : value;
    endfunction

    function void expect_result(hcd_pkg::kind_e kind, logic [7:0] pb,
                                logic [hcd_pkg::LenW-1:0] len, hcd_pkg::err_e code);
      hcd_pkg::result_t r;
      r.kind = kind;
      r.payload = pb;
      r.length = len;
      r.code = code;
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void halt_with(hcd_pkg::err_e code);
      phase = PhHalt;
      expect_result(hcd_pkg::KindErr, 8'h00, '0, code);
    endfunction

    function void take_digit(logic [7:0] c);
      logic [3:0] v;
      if (fault != FaultNone) return;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + hcd_pkg::HexAlphaBase);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + hcd_pkg::HexAlphaBase);
      else begin
        fault = FaultHex;
        return;
      end
      hex_acc = (hex_acc << 4) | {28'd0, v};
      if (hex_acc > {7'd0, max_len}) fault = FaultBig;
    endfunction

    // Note one accepted input transfer and queue any result it causes.
    function void take_byte(logic restart, logic [7:0] b);
      int unsigned n;
      if (restart) begin
        clear_parser();
        return;
      end
      case (phase)
        PhLine: begin
          n = line_bytes + 1;
          if (n > LineLimit) begin
            halt_with(hcd_pkg::ErrLong);
            return;
          end
          line_bytes = n;
          if (b == hcd_pkg::ChLf && cr_seen && n > 2) begin
            cr_seen = 1'b0;
            if (fault == FaultHex) halt_with(hcd_pkg::ErrHex);
            else if (fault == FaultBig) halt_with(hcd_pkg::ErrBig);
            else if (hex_acc == 0) begin
              phase = PhTrail;
              trail_bytes = 0;
            end else begin
              bytes_left = hex_acc[hcd_pkg::LenW-1:0];
              chunk_len = hex_acc[hcd_pkg::LenW-1:0];
              phase = PhData;
            end
            return;
          end
          // a CR not followed by LF counts as line content
          if (cr_seen) take_digit(hcd_pkg::ChCr);
          cr_seen = (b == hcd_pkg::ChCr);
          if (b != hcd_pkg::ChCr) take_digit(b);
        end
        PhData: begin
          if (bytes_left != 0) begin
            bytes_left--;
            expect_result(hcd_pkg::KindByte, b, '0, hcd_pkg::ErrNone);
          end else if (!cr_seen) begin
            first_term = b;
            cr_seen = 1'b1;
          end else if (first_term != hcd_pkg::ChCr || b != hcd_pkg::ChLf) begin
            halt_with(hcd_pkg::ErrTerm);
          end else begin
            phase = PhLine;
            clear_line();
            expect_result(hcd_pkg::KindChunk, 8'h00, chunk_len, hcd_pkg::ErrNone);
          end
        end
        PhTrail: begin
          n = (trail_bytes < 3) ? trail_bytes + 1 : 3;
          if (b == hcd_pkg::ChLf && cr_seen) begin
            cr_seen = 1'b0;
            trail_bytes = 0;
            if (n == 2) begin
              phase = PhLine;
              clear_line();
              expect_result(hcd_pkg::KindMsg, 8'h00, '0, hcd_pkg::ErrNone);
            end
          end else begin
            trail_bytes = n;
            cr_seen = (b == hcd_pkg::ChCr);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [1:0] kind_bits, logic [39:0] data_bits);
      hcd_pkg::result_t         want;
      logic [7:0]               pb;
      logic [hcd_pkg::LenW-1:0] len;
      logic [2:0]               code;
      pb = data_bits[7:0];
      len = data_bits[32:8];
      code = data_bits[35:33];
      case (kind_bits)
        hcd_pkg::KindByte:  payloads++;
        hcd_pkg::KindChunk: chunk_ends++;
        hcd_pkg::KindMsg:   msg_ends++;
        default:            errors++;
      endcase
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: kind %0d, tdata %h", kind_bits, data_bits);
        failures++;
        return;
      end
      want = awaited_results[0];
      awaited_results.delete(0);
      if (kind_bits !== want.kind) begin
        $error("kind mismatch: expected %0d, got %0d", want.kind, kind_bits);
        failures++;
      end
      if (pb !== want.payload) begin
        $error("payload_byte mismatch: expected %0d, got %0d", want.payload, pb);
        failures++;
      end
      if (len !== want.length) begin
        $error("chunk_length mismatch: expected %0d, got %0d", want.length, len);
        failures++;
      end
      if (code !== want.code) begin
        $error("error_code mismatch: expected %0d, got %0d", want.code, code);
        failures++;
      end
    endfunction

    function void finish_check();
      if (awaited_results.size() != 0) begin
        $error("%0d expected results never arrived", awaited_results.size());
        failures += awaited_results.size();
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [hcd_pkg::LenW-1:0] cfg_wdata_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [39:0]              m_axis_tdata;
  logic [1:0]               m_axis_tuser;

  chunked_decode_sb decode_sb;
  body_item_t       body_bytes[$];
  int unsigned      pushed_total = 0;
  int unsigned      accepted_total = 0;
  int unsigned      burst_left = 1;
  int unsigned      gap_left = 0;
  int unsigned      cycle_count = 0;
  rx_mode_e         rx_mode = RxOpen;
  int unsigned      rx_left = 0;
  logic [15:0]      rx_pattern = 16'hFFFF;
  logic [3:0]       rx_tick = '0;

  http_chunked_body_decoder #(
    .LINE_LIMIT(LineLimit),
    .FIFO_DEPTH(hcd_pkg::FifoDepthDef)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decode_sb.take_byte(s_axis_tuser, s_axis_tdata);
      body_bytes.delete(0);
      accepted_total++;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
        gap_left = $urandom_range(1, 6);
      end
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (!rst_ni || body_bytes.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= body_bytes[0].data;
        s_axis_tuser <= body_bytes[0].restart;
      end
    end
  end

  // Receiver: checks each accepted result; the stall mode is picked anew at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      decode_sb.check_output(m_axis_tuser, m_axis_tdata);
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
      rx_pattern = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RxOpen:  m_axis_tready <= 1'b1;
      RxLight: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxHeavy: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= rx_pattern[rx_tick];
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_byte(logic restart, logic [7:0] data);
    body_item_t it;
    it.restart = restart;
    it.data = data;
    body_bytes.insert(body_bytes.size(), it);
    pushed_total++;
  endfunction

  function automatic void push_crlf();
    push_byte(1'b0, hcd_pkg::ChCr);
    push_byte(1'b0, hcd_pkg::ChLf);
  endfunction

  function automatic void push_random(int unsigned count);
    repeat (count) push_byte(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  // Hex digits of value, mixed case, after the given number of leading zeros.
  function automatic void push_hex(logic [31:0] value, int unsigned zeros);
    logic [3:0]  digits[$];
    logic [31:0] rest;
    logic [7:0]  c;
    rest = value;
    do begin
      digits.push_front(rest[3:0]);
      rest = rest >> 4;
    end while (rest != 0);
    repeat (zeros) push_byte(1'b0, "0");
    foreach (digits[i]) begin
      if (digits[i] < 10) c = "0" + digits[i];
      else c = (($urandom_range(0, 1) != 0) ? "A" : "a") + digits[i] - hcd_pkg::HexAlphaBase;
      push_byte(1'b0, c);
    end
  endfunction

  function automatic int unsigned length_cap();
    return (decode_sb.max_len > 24) ? 24 : decode_sb.max_len;
  endfunction

  function automatic void gen_message();
    int unsigned cap, chunks, len;
    cap = length_cap();
    chunks = (cap == 0) ? 0 : $urandom_range(0, 3);
    repeat (chunks) begin
      len = $urandom_range(1, cap);
      if ($urandom_range(0, 9) == 0)
        len = $urandom_range(1, (decode_sb.max_len > 300) ? 300 : decode_sb.max_len);
      push_hex(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
      push_crlf();
      push_random(len);
      push_crlf();
    end
    push_hex(0, $urandom_range(0, 3));
    push_crlf();
    repeat ($urandom_range(0, 2)) begin
      push_random($urandom_range(1, 6));
      push_crlf();
    end
    push_crlf();
  endfunction

  function automatic void gen_fault();
    int unsigned cap, len;
    logic [31:0] value;
    cap = length_cap();
    case ($urandom_range(0, 7))
      0: begin
        // non-hex byte, chunk extensions included; hex fault ahead of a later big value
        push_hex($urandom_range(0, 255), 0);
        case ($urandom_range(0, 3))
          0: push_byte(1'b0, ";");
          1: push_byte(1'b0, "G");
          2: push_byte(1'b0, 8'(8'h80 + $urandom_range(0, 127)));
          default: push_byte(1'b0, " ");
        endcase
        if ($urandom_range(0, 1) != 0) push_hex(32'h0FFF_FFFF, 0);
        push_crlf();
      end
      1: begin
        // around the line limit; short enough lines are zero lengths
        repeat ($urandom_range(29, 40)) push_byte(1'b0, "0");
        push_crlf();
        push_crlf();
      end
      2: begin
        value = decode_sb.max_len + 1 + $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0) value = 32'h0FFF_FFFF;
        push_hex(value, 0);
        if ($urandom_range(0, 1) != 0) push_byte(1'b0, "x");
        push_crlf();
      end
      3: begin
        if (cap == 0) begin
          push_random(4);
        end else begin
          len = $urandom_range(1, cap);
          push_hex(len, 0);
          push_crlf();
          push_random(len);
          case ($urandom_range(0, 2))
            0: begin
              push_byte(1'b0, hcd_pkg::ChCr);
              push_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            1: begin
              push_byte(1'b0, 8'($urandom_range(0, 255)));
              push_byte(1'b0, hcd_pkg::ChLf);
            end
            default: begin
              push_byte(1'b0, hcd_pkg::ChLf);
              push_byte(1'b0, hcd_pkg::ChCr);
            end
          endcase
        end
      end
      4: begin
        // bare CR LF opening a length line
        push_crlf();
        push_hex($urandom_range(0, 15), 0);
        push_crlf();
      end
      5: begin
        push_hex(1, 0);
        push_byte(1'b0, hcd_pkg::ChCr);
        push_hex(2, 0);
        push_crlf();
      end
      6: push_random($urandom_range(1, 12));
      default: begin
        // largest allowed length, cut short by the next restart
        push_hex(decode_sb.max_len, 0);
        push_crlf();
        push_random($urandom_range(1, 6));
      end
    endcase
  endfunction

  function automatic void gen_phase(int unsigned target);
    int unsigned start;
    bit broke;
    start = pushed_total;
    broke = 1'b1;
    while (pushed_total - start < target) begin
      if (broke || $urandom_range(0, 4) == 0) push_byte(1'b1, 8'($urandom_range(0, 255)));
      broke = ($urandom_range(0, 99) < 35);
      if (broke) gen_fault();
      else gen_message();
    end
  endfunction

  task automatic write_limit(logic [hcd_pkg::LenW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    decode_sb.set_limit(value);
  endtask

  task automatic wait_idle();
    while (body_bytes.size() != 0 || decode_sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : main_flow
    logic [hcd_pkg::LenW-1:0] limits[7];
    decode_sb = new();
    limits = '{hcd_pkg::LenCap, 25'h1FF_FFFF, 25'd1, 25'd0, 25'd16, 25'hFF_FFFF, 25'd0};
    limits[6] = 25'($urandom_range(2, 5000));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(1'b0, "1");
    push_crlf();
    push_byte(1'b0, 8'hFF);
    push_crlf();
    push_byte(1'b0, "0");
    push_crlf();
    push_crlf();
    push_crlf();
    push_crlf();
    push_byte(1'b0, 8'h00);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b0, "A");
    push_crlf();
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, hcd_pkg::ChCr);
    push_byte(1'b0, "X");
    push_byte(1'b1, 8'h00);
    wait_idle();

    foreach (limits[i]) begin
      write_limit(limits[i]);
      gen_phase(PhaseItems);
      wait_idle();
    end

    decode_sb.finish_check();
    $display("Run covered %0d input transfers under %0d chunk length limits.",
             accepted_total, $size(limits));
    $display("Seen: %0d payload bytes, %0d chunk ends, %0d message ends, %0d errors.",
             decode_sb.payloads, decode_sb.chunk_ends, decode_sb.msg_ends, decode_sb.errors);
    if (decode_sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/hcd_pkg.sv
design/hcd_front.sv
design/hcd_fifo.sv
design/hcd_back.sv
design/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_test.sv
